// ===== rtl/emboss_pkg.sv =====
// Shared types, sizes and helper functions for the 3x3 emboss filter.
// Depends on nothing; the kernel and the top level of the filter import it.

package emboss_pkg;

    // Largest region the line stores are built for.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Field and register widths.
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    // Derived widths.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SIZE_W  = (MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH + 1)
                                                      : $clog2(MAX_HEIGHT + 1);
    localparam int EXT_W   = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
    localparam int PEND_W  = $clog2(MAX_WIDTH + 2);
    localparam int SLOT_W  = 2;
    localparam int NUM_SLOTS = 3;
    localparam int NUM_TAPS  = 3;

    // Item kinds and register indexes.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = {CH_W{1'b1}};

    typedef logic [PIX_W-1:0] t_pix;

    // Raster position of a stream: column, row and the row slot in use.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SLOT_W-1:0] slot;
    } t_pos;

    // The seven window pixels handed to the kernel.
    typedef struct packed {
        t_pix cen;
        t_pix lft;
        t_pix rgt;
        t_pix up;
        t_pix dn;
        t_pix up_lft;
        t_pix dn_rgt;
    } t_window;

    // Edge flags and write-forward flags that travel with one result.
    typedef struct packed {
        logic has_lft;
        logic has_rgt;
        logic has_up;
        logic has_dn;
        logic fwd_cen;
        logic fwd_lft;
        logic fwd_rgt;
        logic fwd_up;
        logic fwd_dn;
        logic fwd_up_lft;
        logic fwd_dn_rgt;
    } t_tap_ctl;

    // Clamp a programmed size into 1..lim.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (EXT_W'(v) > EXT_W'(lim)) begin
            res = lim;
        end else begin
            res = SIZE_W'(v);
        end
        return res;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(NUM_SLOTS - 1) : s - SLOT_W'(1);
    endfunction

    // Step a raster position by one pixel, wrapping at the region size.
    function automatic t_pos advance_pos(input t_pos p,
                                         input logic [SIZE_W-1:0] w,
                                         input logic [SIZE_W-1:0] h);
        t_pos n;
        n = p;
        if ((SIZE_W'(p.col) + SIZE_W'(1)) >= w) begin
            n.col  = '0;
            n.slot = slot_next(p.slot);
            if ((SIZE_W'(p.row) + SIZE_W'(1)) >= h) begin
                n.row = '0;
            end else begin
                n.row = p.row + ROW_W'(1);
            end
        end else begin
            n.col = p.col + COL_W'(1);
        end
        return n;
    endfunction

endpackage

// ===== rtl/emboss_line_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used for the row stores of the emboss filter.

module emboss_line_ram #(
    parameter  int DEPTH  = 2048,
    parameter  int DATA_W = 24,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/emboss_kernel.sv =====
// Emboss kernel for one 3x3 window: weighted sum per channel, clamped to 8 bits.
// Depends on emboss_pkg for the pixel and window types.

module emboss_kernel
    import emboss_pkg::*;
(
    input  t_window i_win,
    output t_pix    o_pix
);

    localparam int SUM_W = CH_W + 4;

    function automatic logic signed [SUM_W-1:0] ext(input logic [CH_W-1:0] v);
        return $signed({{(SUM_W - CH_W){1'b0}}, v});
    endfunction

    always_comb begin
        logic signed [SUM_W-1:0] sum;
        int sh;
        o_pix = '0;
        for (int k = 0; k < 3; k++) begin
            sh  = CH_W * k;
            sum = ext(i_win.cen[sh +: CH_W]) + ext(i_win.dn[sh +: CH_W])
                + ext(i_win.rgt[sh +: CH_W]) - ext(i_win.up[sh +: CH_W])
                - ext(i_win.lft[sh +: CH_W])
                + (ext(i_win.dn_rgt[sh +: CH_W]) <<< 1)
                - (ext(i_win.up_lft[sh +: CH_W]) <<< 1);
            if (sum < 0) begin
                o_pix[sh +: CH_W] = '0;
            end else if (sum > ext(ALPHA_OPAQUE)) begin
                o_pix[sh +: CH_W] = ALPHA_OPAQUE;
            end else begin
                o_pix[sh +: CH_W] = sum[CH_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/emboss_3x3_filter.sv =====
// Streaming 3x3 emboss filter over a rectangular region, top level.
// A request's result is registered first in the read stage, then in the output register.
// One request per cycle unless stalled, set by the nine line RAMs being read once per result.
// Results lag their pixel by region_width+1 positions; drain requests flush them.
// Reset (synchronous, active low) clears counters and pipeline valids; both sizes return to one.
// The row stores are not cleared; no clearing pass runs after reset.

module emboss_3x3_filter
    import emboss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [CH_W-1:0]      i_in_red,
    input  logic [CH_W-1:0]      i_in_green,
    input  logic [CH_W-1:0]      i_in_blue,
    // result request channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CH_W-1:0]      o_out_red,
    output logic [CH_W-1:0]      o_out_green,
    output logic [CH_W-1:0]      o_out_blue,
    output logic [CH_W-1:0]      o_out_alpha,
    output logic                 o_frame_end
);

    // ------------------------------------------------------------------
    // Size registers. The raw programmed values are kept; the effective
    // size (zero acts as one, large values saturate) is derived below.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(1);
            r_cfg_height <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_HEIGHT: r_cfg_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic [SIZE_W-1:0] w_width;
    logic [SIZE_W-1:0] w_height;

    assign w_width  = eff_size(r_cfg_width, SIZE_W'(MAX_WIDTH));
    assign w_height = eff_size(r_cfg_height, SIZE_W'(MAX_HEIGHT));

    // ------------------------------------------------------------------
    // Stream positions. The input position says where the next pixel is
    // written; the output position is the pixel whose result comes next.
    // Their distance in raster order is the pending count.
    // ------------------------------------------------------------------
    t_pos              r_in_pos;
    t_pos              r_out_pos;
    logic [PEND_W-1:0] r_pending;
    t_pos              n_in_pos;
    t_pos              n_out_pos;
    logic [PEND_W-1:0] n_pending;

    logic w_accept;
    logic w_is_pixel;
    logic w_full;
    logic w_emit;
    logic w_wr_en;
    t_pix w_in_pix;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_is_pixel = (i_mode == MODE_PIXEL);
    assign w_in_pix   = {i_in_red, i_in_green, i_in_blue};

    // The window is complete once region_width+1 pixels are held back.
    assign w_full = SIZE_W'(r_pending) > w_width;

    // A pixel emits only with a full window; a drain emits while anything is pending.
    assign w_emit  = w_accept && (w_is_pixel ? w_full : (r_pending != '0));
    assign w_wr_en = w_accept && w_is_pixel;

    always_comb begin
        n_in_pos  = r_in_pos;
        n_out_pos = r_out_pos;
        n_pending = r_pending;
        if (w_wr_en) begin
            n_in_pos = advance_pos(r_in_pos, w_width, w_height);
        end
        if (w_emit) begin
            n_out_pos = advance_pos(r_out_pos, w_width, w_height);
        end
        if (w_accept) begin
            if (w_is_pixel && !w_full) begin
                n_pending = r_pending + PEND_W'(1);
            end else if (!w_is_pixel && (r_pending != '0)) begin
                n_pending = r_pending - PEND_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pos  <= '0;
            r_out_pos <= '0;
            r_pending <= '0;
        end else begin
            r_in_pos  <= n_in_pos;
            r_out_pos <= n_out_pos;
            r_pending <= n_pending;
        end
    end

    // ------------------------------------------------------------------
    // Row stores. Each of the three row slots is kept in three copies so
    // that the columns left of, at and right of the output column can be
    // read in the same cycle. Every copy takes every write of its slot.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] w_rd_addr [NUM_TAPS];
    t_pix             w_rd_data [NUM_SLOTS][NUM_TAPS];

    always_comb begin
        w_rd_addr[0] = r_out_pos.col - COL_W'(1);
        w_rd_addr[1] = r_out_pos.col;
        w_rd_addr[2] = r_out_pos.col + COL_W'(1);
    end

    for (genvar gs = 0; gs < NUM_SLOTS; gs++) begin : g_slot
        for (genvar gk = 0; gk < NUM_TAPS; gk++) begin : g_tap
            emboss_line_ram #(
                .DEPTH  (MAX_WIDTH),
                .DATA_W (PIX_W)
            ) u_ram (
                .i_clk     (i_clk),
                .i_wr_en   (w_wr_en && (r_in_pos.slot == SLOT_W'(gs))),
                .i_wr_addr (r_in_pos.col),
                .i_wr_data (w_in_pix),
                .i_rd_en   (w_emit),
                .i_rd_addr (w_rd_addr[gk]),
                .o_rd_data (w_rd_data[gs][gk])
            );
        end
    end

    // ------------------------------------------------------------------
    // Edge and forwarding flags, worked out at the request edge. The RAM
    // read sees the contents before this request's write, so a tap that
    // falls on the pixel being written takes the incoming pixel instead.
    // ------------------------------------------------------------------
    t_tap_ctl          w_ctl;
    logic [SLOT_W-1:0] w_slot_up;
    logic [SLOT_W-1:0] w_slot_dn;
    logic              w_end;

    assign w_slot_up = slot_prev(r_out_pos.slot);
    assign w_slot_dn = slot_next(r_out_pos.slot);

    always_comb begin
        w_ctl.has_lft = (r_out_pos.col != '0);
        w_ctl.has_rgt = (SIZE_W'(r_out_pos.col) + SIZE_W'(1)) < w_width;
        w_ctl.has_up  = (r_out_pos.row != '0);
        w_ctl.has_dn  = (SIZE_W'(r_out_pos.row) + SIZE_W'(1)) < w_height;

        w_ctl.fwd_cen    = w_is_pixel && (r_out_pos.slot == r_in_pos.slot)
                           && (w_rd_addr[1] == r_in_pos.col);
        w_ctl.fwd_lft    = w_is_pixel && (r_out_pos.slot == r_in_pos.slot)
                           && (w_rd_addr[0] == r_in_pos.col);
        w_ctl.fwd_rgt    = w_is_pixel && (r_out_pos.slot == r_in_pos.slot)
                           && (w_rd_addr[2] == r_in_pos.col);
        w_ctl.fwd_up     = w_is_pixel && (w_slot_up == r_in_pos.slot)
                           && (w_rd_addr[1] == r_in_pos.col);
        w_ctl.fwd_dn     = w_is_pixel && (w_slot_dn == r_in_pos.slot)
                           && (w_rd_addr[1] == r_in_pos.col);
        w_ctl.fwd_up_lft = w_is_pixel && (w_slot_up == r_in_pos.slot)
                           && (w_rd_addr[0] == r_in_pos.col);
        w_ctl.fwd_dn_rgt = w_is_pixel && (w_slot_dn == r_in_pos.slot)
                           && (w_rd_addr[2] == r_in_pos.col);
    end

    assign w_end = w_ctl.has_rgt == 1'b0 && w_ctl.has_dn == 1'b0;

    // ------------------------------------------------------------------
    // Read stage: RAM data plus the side information registered with it.
    // It holds while the output register is stalled and full.
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    t_tap_ctl          r_s1_ctl;
    logic [SLOT_W-1:0] r_s1_slot;
    t_pix              r_s1_pix;
    logic              r_s1_end;
    logic              w_s1_adv;

    assign w_s1_adv   = r_s1_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_emit) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_s1_ctl  <= w_ctl;
            r_s1_slot <= r_out_pos.slot;
            r_s1_pix  <= w_in_pix;
            r_s1_end  <= w_end;
        end
    end

    // Map the three physical slots onto the rows above, at and below the output.
    t_pix w_mid [NUM_TAPS];
    t_pix w_up  [NUM_TAPS];
    t_pix w_dn  [NUM_TAPS];

    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            case (r_s1_slot)
                SLOT_W'(0): begin
                    w_mid[k] = w_rd_data[0][k];
                    w_up[k]  = w_rd_data[2][k];
                    w_dn[k]  = w_rd_data[1][k];
                end
                SLOT_W'(1): begin
                    w_mid[k] = w_rd_data[1][k];
                    w_up[k]  = w_rd_data[0][k];
                    w_dn[k]  = w_rd_data[2][k];
                end
                default: begin
                    w_mid[k] = w_rd_data[2][k];
                    w_up[k]  = w_rd_data[1][k];
                    w_dn[k]  = w_rd_data[0][k];
                end
            endcase
        end
    end

    // Apply forwarding, then replace any neighbor outside the region by the center.
    t_window w_win;
    t_pix    w_cen;
    t_pix    w_emb;

    always_comb begin
        w_cen = r_s1_ctl.fwd_cen ? r_s1_pix : w_mid[1];
        w_win.cen = w_cen;
        w_win.lft = !r_s1_ctl.has_lft ? w_cen
                  : (r_s1_ctl.fwd_lft ? r_s1_pix : w_mid[0]);
        w_win.rgt = !r_s1_ctl.has_rgt ? w_cen
                  : (r_s1_ctl.fwd_rgt ? r_s1_pix : w_mid[2]);
        w_win.up  = !r_s1_ctl.has_up ? w_cen
                  : (r_s1_ctl.fwd_up ? r_s1_pix : w_up[1]);
        w_win.dn  = !r_s1_ctl.has_dn ? w_cen
                  : (r_s1_ctl.fwd_dn ? r_s1_pix : w_dn[1]);
        w_win.up_lft = !(r_s1_ctl.has_lft && r_s1_ctl.has_up) ? w_cen
                     : (r_s1_ctl.fwd_up_lft ? r_s1_pix : w_up[0]);
        w_win.dn_rgt = !(r_s1_ctl.has_rgt && r_s1_ctl.has_dn) ? w_cen
                     : (r_s1_ctl.fwd_dn_rgt ? r_s1_pix : w_dn[2]);
    end

    emboss_kernel u_kernel (
        .i_win (w_win),
        .o_pix (w_emb)
    );

    // ------------------------------------------------------------------
    // Output register. It frees the read stage as soon as it is taken,
    // so a new request can enter while a result waits here.
    // ------------------------------------------------------------------
    logic r_out_valid;
    t_pix r_out_pix;
    logic r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_pix <= w_emb;
            r_out_end <= r_s1_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_pix[2*CH_W +: CH_W];
    assign o_out_green = r_out_pix[CH_W +: CH_W];
    assign o_out_blue  = r_out_pix[0 +: CH_W];
    assign o_out_alpha = ALPHA_OPAQUE;
    assign o_frame_end = r_out_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every emitting request must occupy the read stage on the next cycle.
    a_emit_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_emit) |=> r_s1_valid)
        else $error("emitting request did not reach the read stage");

    // A pixel taken with a full window keeps the pending count.
    a_full_pixel_keeps_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_accept && w_is_pixel && w_full) |=> (r_pending == $past(r_pending)))
        else $error("pending count moved on a pixel with a full window");

    // A drain that emits lowers the pending count by one.
    a_drain_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_accept && !w_is_pixel && (r_pending != '0))
        |=> (r_pending == $past(r_pending) - PEND_W'(1)))
        else $error("drain did not lower the pending count");

    // The input side is held off only while both pipeline registers are occupied.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free pipeline register");

endmodule
